>>> sv/mfp_pkg.sv
// Shared types and codes for the maze floodfill step planner.
package mfp_pkg;

	localparam int DIST_W = 8;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	localparam logic [1:0] DIR_N = 2'd0;
	localparam logic [1:0] DIR_E = 2'd1;
	localparam logic [1:0] DIR_S = 2'd2;
	localparam logic [1:0] DIR_W = 2'd3;

	typedef enum logic [2:0] {
		MV_FORWARD = 3'd0,
		MV_CW      = 3'd1,
		MV_CCW     = 3'd2,
		MV_AROUND  = 3'd3,
		MV_WAIT    = 3'd4,
		MV_FINISH  = 3'd5
	} mv_t;

	typedef enum logic [2:0] {
		PICK_NONE,
		PICK_LEFT,
		PICK_RIGHT,
		PICK_FRONT,
		PICK_BEHIND
	} pick_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHECK,
		ST_CUR_RD,
		ST_CUR_WB,
		ST_EAST_RD,
		ST_EAST_WB,
		ST_SOUTH_RD,
		ST_SOUTH_WB,
		ST_NB_RD,
		ST_NB_CMP,
		ST_DECIDE,
		ST_FF_START,
		ST_FF_POP,
		ST_FF_CELL_RD,
		ST_FF_CELL,
		ST_FF_NB_RD,
		ST_FF_NB,
		ST_FF_EVAL,
		ST_FF_PUSH,
		ST_DONE
	} state_t;

	// per cell: north wall, west wall, distance
	typedef struct packed {
		logic              wn;
		logic              ww;
		logic [DIST_W-1:0] dval;
	} cell_t;

	typedef struct packed {
		logic clr;
		logic push;
		logic pop;
	} stk_ctrl_t;

endpackage

>>> sv/mfp_cell_mem.sv
// Cell memory: distance and north/west walls per cell, valid bits give reset values.
module mfp_cell_mem import mfp_pkg::*; #(
	parameter int MAZE_SIDE = 16,
	localparam int CB = $clog2(MAZE_SIDE),
	localparam int AW = 2 * CB
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [AW-1:0] rd_addr,
	output cell_t         rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  cell_t         wr_data
);

	localparam int DEPTH = 2 ** AW;
	localparam int HALF = MAZE_SIDE / 2;
	localparam int ODD = MAZE_SIDE % 2;

	cell_t             mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	cell_t             rd_data_s1;
	logic [AW-1:0]     rd_addr_s1;
	logic              rd_valid_s1;

	function automatic logic [DIST_W-1:0] ctr_off(input logic [CB-1:0] v);
		logic [DIST_W-1:0] w;
		w = DIST_W'(v);
		if (ODD == 0)
			return (w < DIST_W'(HALF)) ? DIST_W'(HALF - 1) - w : w - DIST_W'(HALF);
		return (w < DIST_W'(HALF)) ? DIST_W'(HALF) - w : w - DIST_W'(HALF);
	endfunction

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_data_s1 <= mem[rd_addr];
		rd_addr_s1 <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= valid_q[rd_addr];
			if (wr_en)
				valid_q[wr_addr] <= 1'b1;
		end
	end

	always_comb begin
		if (rd_valid_s1) begin
			rd_data = rd_data_s1;
		end else begin
			rd_data.wn   = 1'b0;
			rd_data.ww   = 1'b0;
			rd_data.dval = ctr_off(rd_addr_s1[AW-1:CB]) + ctr_off(rd_addr_s1[CB-1:0]);
		end
	end

endmodule

>>> sv/mfp_stack_mem.sv
// Floodfill work stack: memory with pointer, full pushes are dropped.
module mfp_stack_mem import mfp_pkg::*; #(
	parameter int DEPTH = 512,
	parameter int DW = 8,
	localparam int PW = $clog2(DEPTH),
	localparam int SW = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  stk_ctrl_t     ctrl,
	input  logic [DW-1:0] push_data,
	output logic [DW-1:0] pop_data,
	output logic          empty,
	output logic          drop
);

	logic [DW-1:0] mem [DEPTH];
	logic [SW-1:0] sp_q;
	logic [SW-1:0] sp_dec;
	logic          full;

	assign full   = sp_q == SW'(DEPTH);
	assign empty  = sp_q == '0;
	assign drop   = ctrl.push && full;
	assign sp_dec = sp_q - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else if (ctrl.clr) begin
			sp_q <= '0;
		end else if (ctrl.push && !full) begin
			sp_q <= sp_q + 1'b1;
		end else if (ctrl.pop && !empty) begin
			sp_q <= sp_dec;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push && !full)
			mem[sp_q[PW-1:0]] <= push_data;
		if (ctrl.pop)
			pop_data <= mem[sp_dec[PW-1:0]];
	end

endmodule

>>> sv/maze_floodfill_step_planner_core.sv
// Maze floodfill step planner: visit sequencer around the cell memory and work stack.
//
//   channel | dir | fields (tdata from bit 0)
//   s_*     | in  | cell_x[3:0] cell_y[7:4] heading[9:8] wall_l[10] wall_r[11] wall_f[12]
//   m_*     | out | movement[2:0] stack_overflow[3]
//
// One visit at a time through the cell memory (one read and one write port, registered read).
// A finish visit goes straight to the result. A move updates east/south walls (skipped at the edge).
// Floodfill pops and reads each cell from the stack, skips a cell whose distance is zero,
// and each cell that gets updated pushes its open neighbours.
// Reset: distance map reads as Manhattan distance via valid bits, no clearing pass.
// s_tready is high in idle; a result waits in the output register under m_tready low.
module maze_floodfill_step_planner_core import mfp_pkg::*; #(
	parameter int MAZE_SIDE = 16,
	parameter int STACK_DEPTH = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // cell_x, cell_y, heading, wall_left, wall_right, wall_front
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // movement, stack_overflow
);

	localparam int CB = $clog2(MAZE_SIDE);
	localparam int AW = 2 * CB;
	localparam int HALF = MAZE_SIDE / 2;
	localparam int CLO = (MAZE_SIDE % 2 == 0) ? HALF - 1 : HALF;
	localparam logic [CB-1:0] LAST = CB'(MAZE_SIDE - 1);

	state_t state_q, state_d;

	logic [CB-1:0] c_q, r_q, fc_q, fr_q;
	logic [1:0]    hd_q, k_q, j_q;
	logic          wl_q, wr_q, wf_q;
	logic          start_seen_q;
	logic [DIST_W-1:0] cur_d_q, mn_q, cd_q, nv;
	pick_t         best_q;
	logic          cn_q, cw_q, have_q, ovf_q;
	logic [3:0]    open_q;
	mv_t           res_mv_q;
	logic          res_ovf_q;
	logic          out_valid_q;
	mv_t           out_mv_q;
	logic          out_ovf_q;

	logic [AW-1:0] rd_addr, wr_addr;
	logic          wr_en;
	cell_t         wr_data, rdat;
	stk_ctrl_t     stk;
	logic [AW-1:0] push_data, pop_data;
	logic          stk_empty, stk_drop;

	logic [3:0]    in_x, in_y;
	logic [CB-1:0] x_sat, y_sat;
	logic [1:0]    mv_dir, push_dir;
	logic [3:0]    wset;
	logic          mv_en, mv_hit, ff_wall, ff_open, ff_hit, is_centre;
	logic          take;

	function automatic logic nb_ok(input logic [CB-1:0] c, input logic [CB-1:0] r,
			input logic [1:0] d);
		unique case (d)
			DIR_N:   return r != '0;
			DIR_E:   return c != LAST;
			DIR_S:   return r != LAST;
			default: return c != '0;
		endcase
	endfunction

	function automatic logic [AW-1:0] nb_addr(input logic [CB-1:0] c,
			input logic [CB-1:0] r, input logic [1:0] d);
		unique case (d)
			DIR_N:   return {r - 1'b1, c};
			DIR_E:   return {r, c + 1'b1};
			DIR_S:   return {r + 1'b1, c};
			default: return {r, c - 1'b1};
		endcase
	endfunction

	function automatic mv_t pick_mv(input pick_t p);
		unique case (p)
			PICK_LEFT:   return MV_CCW;
			PICK_RIGHT:  return MV_CW;
			PICK_FRONT:  return MV_FORWARD;
			PICK_BEHIND: return MV_AROUND;
			default:     return MV_FINISH;
		endcase
	endfunction

	mfp_cell_mem #(.MAZE_SIDE(MAZE_SIDE)) u_cells (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_data (rdat),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	mfp_stack_mem #(.DEPTH(STACK_DEPTH), .DW(AW)) u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (stk),
		.push_data (push_data),
		.pop_data  (pop_data),
		.empty     (stk_empty),
		.drop      (stk_drop)
	);

	assign in_x  = s_tdata[3:0];
	assign in_y  = s_tdata[7:4];
	assign x_sat = ({1'b0, in_x} >= 5'(MAZE_SIDE)) ? LAST : in_x[CB-1:0];
	assign y_sat = ({1'b0, in_y} >= 5'(MAZE_SIDE)) ? LAST : in_y[CB-1:0];
	assign take  = s_tvalid && s_tready;

	assign is_centre = (c_q == CB'(CLO) || c_q == CB'(HALF))
		&& (r_q == CB'(CLO) || r_q == CB'(HALF));

	always_comb begin
		for (int d = 0; d < 4; d++)
			wset[d] = (wl_q && 2'(d) == hd_q - 2'd1) || (wr_q && 2'(d) == hd_q + 2'd1)
				|| (wf_q && 2'(d) == hd_q);
	end

	// neighbour order for the move: left, right, front, behind
	always_comb begin
		unique case (k_q)
			2'd0: begin mv_dir = hd_q - 2'd1; mv_en = !wl_q; end
			2'd1: begin mv_dir = hd_q + 2'd1; mv_en = !wr_q; end
			2'd2: begin mv_dir = hd_q;        mv_en = !wf_q; end
			default: begin mv_dir = hd_q + 2'd2; mv_en = best_q == PICK_NONE; end
		endcase
	end

	assign mv_hit = mv_en && nb_ok(c_q, r_q, mv_dir)
		&& ((k_q == 2'd2) ? rdat.dval <= mn_q : rdat.dval < mn_q);

	always_comb begin
		unique case (k_q)
			DIR_N:   ff_wall = cn_q;
			DIR_E:   ff_wall = rdat.ww;
			DIR_S:   ff_wall = rdat.wn;
			default: ff_wall = cw_q;
		endcase
	end

	assign ff_open = nb_ok(fc_q, fr_q, k_q) && !ff_wall;
	assign ff_hit  = ff_open && (!have_q || rdat.dval < mn_q);
	assign nv      = (mn_q == DIST_MAX) ? DIST_MAX : mn_q + 1'b1;

	// push order: west, east, north, south
	always_comb begin
		unique case (j_q)
			2'd0:    push_dir = DIR_W;
			2'd1:    push_dir = DIR_E;
			2'd2:    push_dir = DIR_N;
			default: push_dir = DIR_S;
		endcase
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = {r_q, c_q};
		wr_data   = rdat;
		stk       = '0;
		push_data = {fr_q, fc_q};
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (is_centre || (c_q == '0 && r_q == LAST && start_seen_q))
					state_d = ST_DONE;
				else
					state_d = ST_CUR_RD;
			end
			ST_CUR_RD: begin
				rd_addr = {r_q, c_q};
				state_d = ST_CUR_WB;
			end
			ST_CUR_WB: begin
				wr_en      = 1'b1;
				wr_data.wn = rdat.wn | wset[DIR_N];
				wr_data.ww = rdat.ww | wset[DIR_W];
				state_d    = ST_EAST_RD;
			end
			ST_EAST_RD: begin
				rd_addr = nb_addr(c_q, r_q, DIR_E);
				state_d = nb_ok(c_q, r_q, DIR_E) ? ST_EAST_WB : ST_SOUTH_RD;
			end
			ST_EAST_WB: begin
				wr_en      = 1'b1;
				wr_addr    = nb_addr(c_q, r_q, DIR_E);
				wr_data.ww = rdat.ww | wset[DIR_E];
				state_d    = ST_SOUTH_RD;
			end
			ST_SOUTH_RD: begin
				rd_addr = nb_addr(c_q, r_q, DIR_S);
				state_d = nb_ok(c_q, r_q, DIR_S) ? ST_SOUTH_WB : ST_NB_RD;
			end
			ST_SOUTH_WB: begin
				wr_en      = 1'b1;
				wr_addr    = nb_addr(c_q, r_q, DIR_S);
				wr_data.wn = rdat.wn | wset[DIR_S];
				state_d    = ST_NB_RD;
			end
			ST_NB_RD: begin
				rd_addr = nb_addr(c_q, r_q, mv_dir);
				state_d = ST_NB_CMP;
			end
			ST_NB_CMP: begin
				state_d = (k_q == 2'd3) ? ST_DECIDE : ST_NB_RD;
			end
			ST_DECIDE: begin
				if (mn_q >= cur_d_q) begin
					stk.clr = 1'b1;
					state_d = ST_FF_START;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_FF_START: begin
				stk.push  = 1'b1;
				push_data = {r_q, c_q};
				state_d   = ST_FF_POP;
			end
			ST_FF_POP: begin
				if (stk_empty) begin
					state_d = ST_DONE;
				end else begin
					stk.pop = 1'b1;
					state_d = ST_FF_CELL_RD;
				end
			end
			ST_FF_CELL_RD: begin
				rd_addr = pop_data;
				state_d = ST_FF_CELL;
			end
			ST_FF_CELL: begin
				state_d = (rdat.dval == '0) ? ST_FF_POP : ST_FF_NB_RD;
			end
			ST_FF_NB_RD: begin
				rd_addr = nb_addr(fc_q, fr_q, k_q);
				state_d = ST_FF_NB;
			end
			ST_FF_NB: begin
				state_d = (k_q == 2'd3) ? ST_FF_EVAL : ST_FF_NB_RD;
			end
			ST_FF_EVAL: begin
				if (!have_q || cd_q > mn_q || nv == cd_q) begin
					state_d = ST_FF_POP;
				end else begin
					wr_en        = 1'b1;
					wr_addr      = {fr_q, fc_q};
					wr_data.wn   = cn_q;
					wr_data.ww   = cw_q;
					wr_data.dval = nv;
					state_d      = ST_FF_PUSH;
				end
			end
			ST_FF_PUSH: begin
				stk.push  = open_q[push_dir];
				push_data = nb_addr(fc_q, fr_q, push_dir);
				state_d   = (j_q == 2'd3) ? ST_FF_POP : ST_FF_PUSH;
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			start_seen_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CHECK && !is_centre && c_q == '0 && r_q == LAST)
				start_seen_q <= 1'b1;
			if (state_q == ST_DONE && (!out_valid_q || m_tready))
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					c_q  <= x_sat;
					r_q  <= LAST - y_sat;
					hd_q <= s_tdata[9:8];
					wl_q <= s_tdata[10];
					wr_q <= s_tdata[11];
					wf_q <= s_tdata[12];
				end
			end
			ST_CHECK: begin
				res_mv_q  <= MV_FINISH;
				res_ovf_q <= 1'b0;
			end
			ST_CUR_WB: begin
				cur_d_q <= rdat.dval;
				mn_q    <= rdat.dval;
				best_q  <= PICK_NONE;
				k_q     <= 2'd0;
			end
			ST_NB_CMP: begin
				if (mv_hit) begin
					mn_q <= rdat.dval;
					unique case (k_q)
						2'd0:    best_q <= PICK_LEFT;
						2'd1:    best_q <= PICK_RIGHT;
						2'd2:    best_q <= PICK_FRONT;
						default: best_q <= PICK_BEHIND;
					endcase
				end
				k_q <= k_q + 2'd1;
			end
			ST_DECIDE: begin
				res_mv_q <= pick_mv(best_q);
				ovf_q    <= 1'b0;
			end
			ST_FF_POP: begin
				res_mv_q  <= MV_WAIT;
				res_ovf_q <= ovf_q;
			end
			ST_FF_CELL_RD: begin
				fr_q <= pop_data[AW-1:CB];
				fc_q <= pop_data[CB-1:0];
			end
			ST_FF_CELL: begin
				cd_q   <= rdat.dval;
				cn_q   <= rdat.wn;
				cw_q   <= rdat.ww;
				have_q <= 1'b0;
				k_q    <= 2'd0;
			end
			ST_FF_NB: begin
				open_q[k_q] <= ff_open;
				if (ff_hit) begin
					mn_q   <= rdat.dval;
					have_q <= 1'b1;
				end
				k_q <= k_q + 2'd1;
			end
			ST_FF_EVAL: begin
				j_q <= 2'd0;
			end
			ST_FF_PUSH: begin
				j_q <= j_q + 2'd1;
				if (stk_drop)
					ovf_q <= 1'b1;
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_mv_q  <= res_mv_q;
					out_ovf_q <= res_ovf_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_ovf_q, out_mv_q};

endmodule

>>> sv/mfp_port_checker.sv
// Port-level checks for the maze floodfill step planner, bound to the top level.
module mfp_port_checker import mfp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata
);

	a_mv_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= MV_FINISH)
		else $error("movement code out of range");

	a_ovf_wait: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> m_tdata[2:0] == MV_WAIT)
		else $error("overflow flag without wait");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind maze_floodfill_step_planner_core mfp_port_checker u_port_checker (.*);

>>> dv/tb_top.sv
// Testbench for the maze floodfill step planner: directed and random traffic checked against an in-bench model.
`timescale 1ns / 100ps

module tb_top;
	import mfp_pkg::*;

	localparam int SIDE = 16;
	localparam int STK_DEPTH = 512;
	localparam int CYCLE_LIMIT = 4000000;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [15:0] s_tdata;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;

	typedef struct packed {
		mv_t  movement;
		logic overflow;
	} plan_t;

	logic [7:0] dist_q [SIDE*SIDE];
	logic       hwall_q [SIDE+1][SIDE];
	logic       vwall_q [SIDE][SIDE+1];
	logic       start_visited;
	logic [7:0] flood_stack [STK_DEPTH];
	int         flood_sp;
	logic       flood_ovf;

	plan_t      expected_plans [$];
	int         error_count;
	int         cycle_count;
	int         send_idle_pct;
	int         recv_idle_pct;
	logic       recv_hold;

	maze_floodfill_step_planner_core #(
		.MAZE_SIDE(SIDE),
		.STACK_DEPTH(STK_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic int centre_ofs(int v);
		return v < SIDE/2 ? SIDE/2 - 1 - v : v - SIDE/2;
	endfunction

	function automatic bit grid_step(int c, int r, int d, output int n);
		n = 0;
		case (d & 3)
			DIR_N: begin
				if (r == 0) return 0;
				r--;
			end
			DIR_E: begin
				if (c + 1 >= SIDE) return 0;
				c++;
			end
			DIR_S: begin
				if (r + 1 >= SIDE) return 0;
				r++;
			end
			default: begin
				if (c == 0) return 0;
				c--;
			end
		endcase
		n = r*SIDE + c;
		return 1;
	endfunction

	function automatic bit has_wall(int c, int r, int d);
		case (d & 3)
			DIR_N: return hwall_q[r][c];
			DIR_E: return vwall_q[r][c+1];
			DIR_S: return hwall_q[r+1][c];
			default: return vwall_q[r][c];
		endcase
	endfunction

	function automatic void mark_wall(int c, int r, int d);
		case (d & 3)
			DIR_N: hwall_q[r][c] = 1'b1;
			DIR_E: vwall_q[r][c+1] = 1'b1;
			DIR_S: hwall_q[r+1][c] = 1'b1;
			default: vwall_q[r][c] = 1'b1;
		endcase
	endfunction

	function automatic bit open_nb(int c, int r, int d, output int n);
		n = 0;
		if (has_wall(c, r, d)) return 0;
		return grid_step(c, r, d, n);
	endfunction

	function automatic void flood_push(int cell_idx);
		if (flood_sp >= STK_DEPTH) begin
			flood_ovf = 1'b1;
		end else begin
			flood_stack[flood_sp] = cell_idx[7:0];
			flood_sp++;
		end
	endfunction

	function automatic void repair_distances(int start);
		int push_dir [4] = '{DIR_W, DIR_E, DIR_N, DIR_S};
		int cell_idx, c, r, n, cd, mn, nv;
		bit have;
		flood_sp = 0;
		flood_push(start);
		while (flood_sp > 0) begin
			flood_sp--;
			cell_idx = flood_stack[flood_sp];
			c = cell_idx % SIDE;
			r = cell_idx / SIDE;
			cd = dist_q[cell_idx];
			if (cd == 0) continue;
			have = 0;
			mn = 0;
			for (int d = 0; d < 4; d++)
				if (open_nb(c, r, d, n) && (!have || dist_q[n] < mn)) begin
					mn = dist_q[n];
					have = 1;
				end
			if (!have || cd > mn) continue;
			nv = mn < 255 ? mn + 1 : 255;
			if (nv == cd) continue;
			dist_q[cell_idx] = nv[7:0];
			for (int d = 0; d < 4; d++)
				if (open_nb(c, r, push_dir[d], n)) flood_push(n);
		end
	endfunction

	task automatic reset_planner_model();
		for (int r = 0; r < SIDE; r++)
			for (int c = 0; c < SIDE; c++)
				dist_q[r*SIDE+c] = 8'(centre_ofs(r) + centre_ofs(c));
		for (int r = 0; r <= SIDE; r++)
			for (int c = 0; c < SIDE; c++)
				hwall_q[r][c] = (r == 0 || r == SIDE);
		for (int r = 0; r < SIDE; r++)
			for (int c = 0; c <= SIDE; c++)
				vwall_q[r][c] = (c == 0 || c == SIDE);
		start_visited = 1'b0;
		flood_sp = 0;
	endtask

	function automatic plan_t plan_visit(logic [12:0] req);
		int x, y, hd, dl, dr, db, c, r, cur, mn, n;
		bit wl, wr, wf;
		pick_t best;
		plan_t p;
		x = req[3:0];
		y = req[7:4];
		hd = req[9:8];
		wl = req[10];
		wr = req[11];
		wf = req[12];
		dl = (hd + 3) & 3;
		dr = (hd + 1) & 3;
		db = (hd + 2) & 3;
		best = PICK_NONE;
		p.movement = MV_FINISH;
		p.overflow = 1'b0;
		if (centre_ofs(x) == 0 && centre_ofs(y) == 0) return p;
		if (x == 0 && y == 0) begin
			if (start_visited) return p;
			start_visited = 1'b1;
		end
		c = x;
		r = SIDE - 1 - y;
		cur = dist_q[r*SIDE+c];
		mn = cur;
		if (wl) mark_wall(c, r, dl);
		if (wr) mark_wall(c, r, dr);
		if (wf) mark_wall(c, r, hd);
		if (!wl && grid_step(c, r, dl, n) && dist_q[n] < mn) begin
			mn = dist_q[n];
			best = PICK_LEFT;
		end
		if (!wr && grid_step(c, r, dr, n) && dist_q[n] < mn) begin
			mn = dist_q[n];
			best = PICK_RIGHT;
		end
		if (!wf && grid_step(c, r, hd, n) && dist_q[n] <= mn) begin
			mn = dist_q[n];
			best = PICK_FRONT;
		end
		if (best == PICK_NONE && grid_step(c, r, db, n) && dist_q[n] < mn) begin
			mn = dist_q[n];
			best = PICK_BEHIND;
		end
		if (mn >= cur) begin
			flood_ovf = 1'b0;
			repair_distances(r*SIDE + c);
			p.movement = MV_WAIT;
			p.overflow = flood_ovf;
			return p;
		end
		case (best)
			PICK_LEFT: p.movement = MV_CCW;
			PICK_RIGHT: p.movement = MV_CW;
			PICK_FRONT: p.movement = MV_FORWARD;
			PICK_BEHIND: p.movement = MV_AROUND;
			default: p.movement = MV_FINISH;
		endcase
		return p;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
		error_count++;
	endtask

	task automatic send_visit(int x, int y, int hd, bit wl, bit wr, bit wf);
		logic [12:0] req;
		req = {wf, wr, wl, hd[1:0], y[3:0], x[3:0]};
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, req};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_plans.push_back(plan_visit(req));
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_plans.size() != 0) @(posedge clk);
	endtask

	task automatic send_random_visit();
		send_visit($urandom_range(15), $urandom_range(15), $urandom_range(3),
			$urandom_range(1), $urandom_range(1), $urandom_range(1));
	endtask

	task automatic test_directed();
		send_visit(0, 0, DIR_N, 1, 0, 0);
		send_visit(7, 7, DIR_E, 0, 0, 0);
		send_visit(8, 8, DIR_W, 1, 1, 1);
		send_visit(15, 15, DIR_S, 1, 1, 1);
		send_visit(15, 0, DIR_W, 0, 0, 0);
		send_visit(0, 15, DIR_E, 0, 1, 0);
		for (int h = 0; h < 4; h++) send_visit(3, 4, h, 0, 0, 0);
		for (int h = 0; h < 4; h++) send_visit(5, 5, h, 1, 1, 1);
		send_visit(6, 7, DIR_E, 1, 1, 1);
		send_visit(6, 7, DIR_N, 0, 1, 1);
		send_visit(10, 3, DIR_S, 1, 0, 1);
		send_visit(2, 12, DIR_W, 0, 1, 1);
		send_visit(0, 0, DIR_E, 0, 0, 0);
		drain_results();
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(3) == 0) send_visit($urandom_range(15), $urandom_range(15),
				$urandom_range(3), 1, 1, 1);
			else send_random_visit();
		end
		drain_results();
	endtask

	task automatic test_backpressure();
		recv_hold = 1'b1;
		for (int i = 0; i < 6; i++) send_random_visit();
		drain_results();
	endtask

	task automatic test_after_pause();
		repeat (3000) @(posedge clk);
		for (int i = 0; i < 5; i++) send_random_visit();
		drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		error_count = 0;
		recv_hold = 1'b0;
		send_idle_pct = 8;
		recv_idle_pct = 62;
		reset_planner_model();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(45);
		send_idle_pct = 62;
		recv_idle_pct = 8;
		test_random(45);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_backpressure();
		test_after_pause();
		test_random(20);
		repeat (3000) @(posedge clk);
		if (error_count == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (recv_hold) begin
				recv_hold = 1'b0;
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		plan_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_plans.size() == 0) begin
				report_mismatch("unexpected result", m_tdata, 0);
			end else begin
				want = expected_plans.pop_front();
				if (m_tdata[2:0] != want.movement)
					report_mismatch("movement", m_tdata[2:0], want.movement);
				if (m_tdata[3] != want.overflow)
					report_mismatch("stack_overflow", m_tdata[3], want.overflow);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial cycle_count = 0;

endmodule
